### hw/rtl/rsi_pkg.sv
// Shared types and constants for the ray/sphere intersection pipeline.
// No dependencies.
`timescale 1ns / 1ps

package rsi_pkg;

  typedef enum logic [1:0] {
    CFG_CENTER_X = 2'd0,
    CFG_CENTER_Y = 2'd1,
    CFG_CENTER_Z = 2'd2,
    CFG_RADIUS   = 2'd3
  } rsi_cfg_e;

  localparam int unsigned H_W    = 67;   // h = L.D, signed
  localparam int unsigned A_W    = 64;   // a = D.D, unsigned
  localparam int unsigned DISC_W = 132;  // non-negative discriminant
  localparam int unsigned ROOT_W = DISC_W / 2;
  localparam int unsigned T_W    = 31;
  localparam int unsigned N_W    = A_W + T_W;  // dividend bits into the divider

  localparam logic [T_W-1:0] T_MAX = {T_W{1'b1}};

  typedef struct packed {
    logic [H_W-1:0] h;
    logic [A_W-1:0] a;
    logic           degen;
    logic           neg;
  } sq_side_t;

  typedef struct packed {
    logic pos_n;
    logic pos_f;
    logic sat_n;
    logic sat_f;
    logic kill;
    logic degen;
  } dv_side_t;

endpackage

### hw/rtl/rsi_isqrt_pipe.sv
// Pipelined floor square root, one result bit per stage, with sideband.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module rsi_isqrt_pipe #(
  parameter int unsigned XW = 132,
  parameter int unsigned SW = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [XW-1:0]   x_i,
  input  logic [SW-1:0]   side_i,
  output logic            valid_o,
  output logic [XW/2-1:0] root_o,
  output logic [SW-1:0]   side_o
);

  localparam int unsigned NS = XW / 2;
  localparam int unsigned RW = NS + 2;

  logic [RW-1:0] rem_q  [NS];
  logic [NS-1:0] root_q [NS];
  logic [XW-1:0] x_q    [NS];
  logic [SW-1:0] side_q [NS];
  logic [NS-1:0] v_q;

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [RW-1:0] rem_in, rem_sh, trial;
    logic [NS-1:0] root_in;
    logic [XW-1:0] x_in;
    logic [SW-1:0] side_in;
    logic          v_in, ge;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign x_in    = x_i;
      assign side_in = side_i;
      assign v_in    = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign x_in    = x_q[k-1];
      assign side_in = side_q[k-1];
      assign v_in    = v_q[k-1];
    end

    assign rem_sh = {rem_in[RW-3:0], x_in[XW-1 -: 2]};
    assign trial  = {root_in, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? rem_sh - trial : rem_sh;
        root_q[k] <= {root_in[NS-2:0], ge};
        x_q[k]    <= {x_in[XW-3:0], 2'b00};
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = v_q[NS-1];
  assign root_o  = root_q[NS-1];
  assign side_o  = side_q[NS-1];

endmodule

### hw/rtl/rsi_div_pipe.sv
// Two-lane pipelined restoring divider with a shared divisor, one
// quotient bit per stage. Dividend high part must be below the divisor.
`timescale 1ns / 1ps

module rsi_div_pipe #(
  parameter int unsigned AW = 64,
  parameter int unsigned QW = 31,
  parameter int unsigned SW = 5
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [AW+QW-1:0] n_near_i,
  input  logic [AW+QW-1:0] n_far_i,
  input  logic [AW-1:0]    a_i,
  input  logic [SW-1:0]    side_i,
  output logic             valid_o,
  output logic [QW-1:0]    q_near_o,
  output logic [QW-1:0]    q_far_o,
  output logic [SW-1:0]    side_o
);

  logic [AW-1:0] rn_q [QW];
  logic [AW-1:0] rf_q [QW];
  logic [QW-1:0] ln_q [QW];
  logic [QW-1:0] lf_q [QW];
  logic [QW-1:0] qn_q [QW];
  logic [QW-1:0] qf_q [QW];
  logic [AW-1:0] a_q  [QW];
  logic [SW-1:0] sd_q [QW];
  logic [QW-1:0] v_q;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [AW-1:0] rn_in, rf_in, a_in;
    logic [QW-1:0] ln_in, lf_in, qn_in, qf_in;
    logic [SW-1:0] sd_in;
    logic          v_in, gen, gef;
    logic [AW:0]   tn, tf, tn_s, tf_s;

    if (k == 0) begin : g_first
      assign rn_in = n_near_i[AW+QW-1:QW];
      assign rf_in = n_far_i[AW+QW-1:QW];
      assign ln_in = n_near_i[QW-1:0];
      assign lf_in = n_far_i[QW-1:0];
      assign qn_in = '0;
      assign qf_in = '0;
      assign a_in  = a_i;
      assign sd_in = side_i;
      assign v_in  = valid_i;
    end else begin : g_next
      assign rn_in = rn_q[k-1];
      assign rf_in = rf_q[k-1];
      assign ln_in = ln_q[k-1];
      assign lf_in = lf_q[k-1];
      assign qn_in = qn_q[k-1];
      assign qf_in = qf_q[k-1];
      assign a_in  = a_q[k-1];
      assign sd_in = sd_q[k-1];
      assign v_in  = v_q[k-1];
    end

    assign tn   = {rn_in, ln_in[QW-1]};
    assign tf   = {rf_in, lf_in[QW-1]};
    assign gen  = tn >= {1'b0, a_in};
    assign gef  = tf >= {1'b0, a_in};
    assign tn_s = tn - {1'b0, a_in};
    assign tf_s = tf - {1'b0, a_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rn_q[k] <= gen ? tn_s[AW-1:0] : tn[AW-1:0];
        rf_q[k] <= gef ? tf_s[AW-1:0] : tf[AW-1:0];
        ln_q[k] <= {ln_in[QW-2:0], 1'b0};
        lf_q[k] <= {lf_in[QW-2:0], 1'b0};
        qn_q[k] <= {qn_in[QW-2:0], gen};
        qf_q[k] <= {qf_in[QW-2:0], gef};
        a_q[k]  <= a_in;
        sd_q[k] <= sd_in;
      end
    end
  end

  assign valid_o  = v_q[QW-1];
  assign q_near_o = qn_q[QW-1];
  assign q_far_o  = qf_q[QW-1];
  assign side_o   = sd_q[QW-1];

endmodule

### hw/rtl/ray_sphere_intersect_unit.sv
// Ray/sphere test: one request per cycle unless a result waits at the
// output; depth is set by the 66-stage square root and the 31-stage
// divider. The whole pipeline stalls while a result waits; the input
// register still fills if empty. Reset clears the valid bits and the
// sphere registers.
// Uses rsi_pkg, rsi_isqrt_pipe, rsi_div_pipe.
`timescale 1ns / 1ps

module ray_sphere_intersect_unit
  import rsi_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned EPS_LSB   = 3
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
  input  logic [191:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // hit_count, any_hit, near_valid, far_valid, t_near, t_far, t_first, pad
  output logic [103:0] m_axis_tdata,
  // degenerate
  output logic [0:0]   m_axis_tuser
);

  localparam int unsigned WW = 96;

  logic [31:0] cx_q, cy_q, cz_q;
  logic [30:0] rad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q  <= '0;
      cy_q  <= '0;
      cz_q  <= '0;
      rad_q <= '0;
    end else if (cfg_we_i) begin
      case (rsi_cfg_e'(cfg_idx_i))
        CFG_CENTER_X: cx_q  <= cfg_data_i;
        CFG_CENTER_Y: cy_q  <= cfg_data_i;
        CFG_CENTER_Z: cz_q  <= cfg_data_i;
        CFG_RADIUS:   rad_q <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  logic en, en0, out_v_q;
  assign en  = !out_v_q || m_axis_tready;

  // stage 0: input register
  logic        v0_q;
  logic [31:0] o0_q [3];
  logic [31:0] d0_q [3];
  assign en0           = en || !v0_q;
  assign s_axis_tready = en0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v0_q <= 1'b0;
    else if (en0) v0_q <= s_axis_tvalid;
  end
  always_ff @(posedge clk_i) begin
    if (en0 && s_axis_tvalid) begin
      for (int i = 0; i < 3; i++) begin
        o0_q[i] <= s_axis_tdata[32*i +: 32];
        d0_q[i] <= s_axis_tdata[96 + 32*i +: 32];
      end
    end
  end

  // stage 1: L = O - C
  logic        v1_q;
  logic [32:0] l1_q [3];
  logic [31:0] d1_q [3];
  logic [31:0] cen [3];
  assign cen[0] = cx_q;
  assign cen[1] = cy_q;
  assign cen[2] = cz_q;

  // stage 2: products
  logic        v2_q;
  logic [62:0] dd2_q [3];
  logic [64:0] ld2_q [3];
  logic [64:0] ll2_q [3];
  logic [61:0] rr2_q;

  logic signed [63:0] dd_p [3];
  logic signed [64:0] ld_p [3];
  logic signed [64:0] ll_p [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dd_p[i] = $signed(d1_q[i]) * $signed(d1_q[i]);
      ld_p[i] = $signed(l1_q[i]) * $signed(d1_q[i]);
      ll_p[i] = $signed(l1_q[i]) * $signed(l1_q[i]);
    end
  end

  // stage 3: a, h, c
  logic           v3_q;
  logic [A_W-1:0] a3_q;
  logic [H_W-1:0] h3_q;
  logic [66:0]    c3_q;

  // stage 4: |h|, degenerate
  logic           v4_q, dg4_q;
  logic [A_W-1:0] a4_q;
  logic [H_W-1:0] h4_q;
  logic [65:0]    ha4_q;
  logic [66:0]    c4_q;

  // stage 5: partial products
  logic           v5_q, dg5_q;
  logic [A_W-1:0] a5_q;
  logic [H_W-1:0] h5_q;
  logic [65:0]    pll5_q, plh5_q, phh5_q, q005_q, q105_q, q015_q, q115_q;

  // stage 6: h*h and a*c
  logic           v6_q, dg6_q;
  logic [A_W-1:0] a6_q;
  logic [H_W-1:0] h6_q;
  logic [131:0]   hh6_q;
  logic [137:0]   ac6_q;

  // stage 7: discriminant
  logic              v7_q;
  logic [DISC_W-1:0] x7_q;
  sq_side_t          sd7_q;

  logic [137:0] disc_d;
  logic [65:0]  p_ll, p_lh, p_hh;
  logic signed [65:0] p01, p11;
  logic [65:0] p00, p10;

  assign p_ll = ha4_q[32:0] * ha4_q[32:0];
  assign p_lh = ha4_q[32:0] * ha4_q[65:33];
  assign p_hh = ha4_q[65:33] * ha4_q[65:33];
  assign p00  = a4_q[31:0] * c4_q[33:0];
  assign p10  = a4_q[63:32] * c4_q[33:0];
  assign p01  = $signed({1'b0, a4_q[31:0]}) * $signed(c4_q[66:34]);
  assign p11  = $signed({1'b0, a4_q[63:32]}) * $signed(c4_q[66:34]);
  assign disc_d = 138'(hh6_q) - ac6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      {v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q} <= '0;
    end else if (en) begin
      {v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q} <= {v0_q, v1_q, v2_q, v3_q, v4_q, v5_q, v6_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        l1_q[i]  <= {o0_q[i][31], o0_q[i]} - {cen[i][31], cen[i]};
        d1_q[i]  <= d0_q[i];
        dd2_q[i] <= dd_p[i][62:0];
        ld2_q[i] <= ld_p[i];
        ll2_q[i] <= ll_p[i];
      end
      rr2_q <= rad_q * rad_q;

      a3_q <= 64'(dd2_q[0]) + 64'(dd2_q[1]) + 64'(dd2_q[2]);
      h3_q <= H_W'($signed(ld2_q[0])) + H_W'($signed(ld2_q[1])) + H_W'($signed(ld2_q[2]));
      c3_q <= 67'(ll2_q[0]) + 67'(ll2_q[1]) + 67'(ll2_q[2]) - 67'(rr2_q);

      a4_q  <= a3_q;
      h4_q  <= h3_q;
      c4_q  <= c3_q;
      dg4_q <= a3_q == '0;
      ha4_q <= h3_q[H_W-1] ? 66'(-h3_q) : h3_q[65:0];

      a5_q   <= a4_q;
      h5_q   <= h4_q;
      dg5_q  <= dg4_q;
      pll5_q <= p_ll;
      plh5_q <= p_lh;
      phh5_q <= p_hh;
      q005_q <= p00;
      q105_q <= p10;
      q015_q <= p01;
      q115_q <= p11;

      a6_q  <= a5_q;
      h6_q  <= h5_q;
      dg6_q <= dg5_q;
      hh6_q <= (132'(phh5_q) << 66) + (132'(plh5_q) << 34) + 132'(pll5_q);
      ac6_q <= 138'(q005_q) + (138'(q105_q) << 32)
             + (138'($signed(q015_q)) << 34) + (138'($signed(q115_q)) << 66);

      x7_q        <= disc_d[137] ? '0 : disc_d[DISC_W-1:0];
      sd7_q.h     <= h6_q;
      sd7_q.a     <= a6_q;
      sd7_q.degen <= dg6_q;
      sd7_q.neg   <= disc_d[137];
    end
  end

  // square root
  logic              vs;
  logic [ROOT_W-1:0] s_root;
  sq_side_t          sds;

  rsi_isqrt_pipe #(
    .XW (DISC_W),
    .SW ($bits(sq_side_t))
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v7_q),
    .x_i     (x7_q),
    .side_i  (sd7_q),
    .valid_o (vs),
    .root_o  (s_root),
    .side_o  (sds)
  );

  // stage a: numerators
  logic           va_q, killa_q, dga_q;
  logic [A_W-1:0] aa_q;
  logic [69:0]    nn_a_q, nf_a_q;
  logic [69:0]    hx;
  assign hx = 70'($signed(sds.h));

  // stage b: sign, saturation, dividend
  logic           vb_q;
  logic [A_W-1:0] ab_q;
  logic [N_W-1:0] nn_b_q, nf_b_q;
  dv_side_t       sdb_q;

  logic [WW-1:0] bound, nzn, nzf, shn, shf;
  logic          pos_n, pos_f, sat_n, sat_f;
  assign bound = WW'(aa_q) << (T_W - FRAC_BITS);
  assign nzn   = WW'(nn_a_q[68:0]);
  assign nzf   = WW'(nf_a_q[68:0]);
  assign shn   = nzn << FRAC_BITS;
  assign shf   = nzf << FRAC_BITS;
  assign pos_n = !nn_a_q[69] && (nn_a_q != '0);
  assign pos_f = !nf_a_q[69] && (nf_a_q != '0);
  assign sat_n = nzn >= bound;
  assign sat_f = nzf >= bound;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else if (en) begin
      va_q <= vs;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      aa_q    <= sds.a;
      killa_q <= sds.degen || sds.neg;
      dga_q   <= sds.degen;
      nn_a_q  <= (~hx + 70'd1) - 70'(s_root);
      nf_a_q  <= (~hx + 70'd1) + 70'(s_root);

      ab_q        <= aa_q;
      nn_b_q      <= (pos_n && !sat_n) ? shn[N_W-1:0] : '0;
      nf_b_q      <= (pos_f && !sat_f) ? shf[N_W-1:0] : '0;
      sdb_q.pos_n <= pos_n;
      sdb_q.pos_f <= pos_f;
      sdb_q.sat_n <= sat_n;
      sdb_q.sat_f <= sat_f;
      sdb_q.kill  <= killa_q;
      sdb_q.degen <= dga_q;
    end
  end

  // divider
  logic           vd;
  logic [T_W-1:0] qn, qf;
  dv_side_t       sdd;

  rsi_div_pipe #(
    .AW (A_W),
    .QW (T_W),
    .SW ($bits(dv_side_t))
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (vb_q),
    .n_near_i (nn_b_q),
    .n_far_i  (nf_b_q),
    .a_i      (ab_q),
    .side_i   (sdb_q),
    .valid_o  (vd),
    .q_near_o (qn),
    .q_far_o  (qf),
    .side_o   (sdd)
  );

  // output register
  logic           vn, vf;
  logic [T_W-1:0] tn, tf;
  logic [1:0]     cnt;
  logic [103:0]   data_d;
  logic [103:0]   data_q;
  logic           user_q;

  always_comb begin
    vn  = sdd.pos_n && !sdd.kill && (sdd.sat_n || (qn > T_W'(EPS_LSB)));
    vf  = sdd.pos_f && !sdd.kill && (sdd.sat_f || (qf > T_W'(EPS_LSB)));
    tn  = vn ? (sdd.sat_n ? T_MAX : qn) : '0;
    tf  = vf ? (sdd.sat_f ? T_MAX : qf) : '0;
    cnt = 2'(vn) + 2'(vf);
    data_d = {6'b0, (vn ? tn : tf), tf, tn, vf, vn, (vn || vf), cnt};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (en) out_v_q <= vd;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      data_q <= data_d;
      user_q <= sdd.degen;
    end
  end

  assign m_axis_tvalid   = out_v_q;
  assign m_axis_tdata    = data_q;
  assign m_axis_tuser[0] = user_q;

`ifndef SYNTHESIS
  a_degen_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("degenerate result with nonzero fields");
  a_any_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[2] == (m_axis_tdata[1:0] != 2'd0)))
    else $error("any_hit disagrees with hit_count");
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[1:0] == 2'(m_axis_tdata[3]) + 2'(m_axis_tdata[4]))
    else $error("hit_count disagrees with root flags");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
    else $error("input stalled while pipeline advances");
`endif

endmodule
